FILE: rtl/core/ffsg_pkg.sv
package ffsg_pkg;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_AV,
      S_AVC,
      S_RD,
      S_LD,
      S_A1,
      S_A2,
      S_A3,
      S_A4,
      S_A4B,
      S_A5,
      S_A6,
      S_A7,
      S_A8,
      S_A9,
      S_A10,
      S_A11,
      S_A12,
      S_A13,
      S_C0,
      S_C1,
      S_C2,
      S_MV_RD,
      S_MV_WR,
      S_F1,
      S_F2,
      S_F3,
      S_F4,
      S_F5,
      S_F_END,
      S_DONE
   } state_type;

   // operations of the shared adder
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } aluop_type;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] RSP_OK         = 2'd0;
   localparam logic [1:0] RSP_NOMEM      = 2'd1;
   localparam logic [1:0] RSP_NOFIT      = 2'd2;
   localparam logic [1:0] RSP_BADHANDLE  = 2'd3;

   // segment kinds
   localparam logic [2:0] KIND_FREE    = 3'd0;
   localparam logic [2:0] KIND_BUFFER  = 3'd1;
   localparam logic [2:0] KIND_IMAGE   = 3'd2;
   localparam logic [2:0] KIND_LINEAR  = 3'd3;
   localparam logic [2:0] KIND_OPTIMAL = 3'd4;

   // register indexes
   localparam logic CSR_POOL_SIZE = 1'b0;
   localparam logic CSR_GRAN_LOG2 = 1'b1;

   // do two kinds conflict when they share a page
   function automatic logic kinds_clash(input logic [2:0] ka, input logic [2:0] kb);
      logic [2:0] lo;
      logic [2:0] hi;
      logic       clash;
      lo = (ka < kb) ? ka : kb;
      hi = (ka < kb) ? kb : ka;
      unique case (lo)
         KIND_FREE:    clash = 1'b0;
         KIND_BUFFER:  clash = (hi == KIND_IMAGE) || (hi == KIND_OPTIMAL);
         KIND_IMAGE:   clash = (hi == KIND_IMAGE) || (hi == KIND_LINEAR) ||
                               (hi == KIND_OPTIMAL);
         KIND_LINEAR:  clash = (hi == KIND_OPTIMAL);
         KIND_OPTIMAL: clash = 1'b0;
         default:      clash = 1'b1;
      endcase
      return clash;
   endfunction

endpackage

FILE: rtl/core/first_fit_suballocator_granularity.sv
// allocate: walks the segments, then on a split moves segments up to open a slot;
// free: walks the segments, then on a merge moves segments down to close the gap
// throughput: one request at a time, set by the single read port of the segment table
// and the one shared adder that does the offset, padding and page-boundary sums
// reset: synchronous, resets the counters and clears the handshakes, then rewrites entry zero
module first_fit_suballocator_granularity #(
   parameter int MAX_SEGMENTS = 64,
   parameter int ADDR_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_request_size,
   input  logic [4:0]  req_align_log2,
   input  logic [2:0]  req_resource_type,
   input  logic [15:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_grant_handle,
   output logic [31:0] rsp_grant_offset,
   output logic [31:0] rsp_grant_size,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = ADDR_BITS;
   localparam int XW = ((AW > 32) ? AW : 32) + 2;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int EW = 2 * AW + 19;

   ffsg_pkg::state_type state_ff, state_in;
   ffsg_pkg::aluop_type alu_op;
   logic [XW-1:0] alu_a, alu_b, alu_y;
   logic          alu_borrow;

   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata, rd_data;

   logic [CW-1:0] idx_ff, idx_in, count_ff, count_in, src_ff, src_in, dst_ff, dst_in;
   logic [AW-1:0] prv_start_ff, prv_start_in, prv_len_ff, prv_len_in;
   logic [2:0]    prv_kind_ff, prv_kind_in;
   logic [15:0]   prv_ident_ff, prv_ident_in;
   logic [AW-1:0] cur_start_ff, cur_start_in, cur_len_ff, cur_len_in;
   logic [15:0]   cur_ident_ff, cur_ident_in;
   logic [AW-1:0] nxt_start_ff, nxt_start_in, nxt_len_ff, nxt_len_in;
   logic          nm_ff, nm_in, mvup_ff, mvup_in, opc_ff, opc_in, init_ff, init_in;
   logic [1:0]    rcnt_ff, rcnt_in;
   logic [XW-1:0] offset_ff, offset_in, tmp_ff, tmp_in, padded_ff, padded_in;
   logic [XW-1:0] rem_ff, rem_in, avail_ff, avail_in;
   logic [31:0]   size_ff, size_in;
   logic [4:0]    alog_ff, alog_in, gl_ff, gl_in;
   logic [2:0]    rtype_ff, rtype_in;
   logic [15:0]   hnd_ff, hnd_in, nid_ff, nid_in;
   logic [AW-1:0] biu_ff, biu_in, pool_ff, pool_in;
   logic [1:0]    res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;
   logic [15:0]   res_handle_ff, res_handle_in, rsp_handle_ff, rsp_handle_in;
   logic [31:0]   res_offset_ff, res_offset_in, rsp_offset_ff, rsp_offset_in;
   logic [31:0]   res_size_ff, res_size_in, rsp_size_ff, rsp_size_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] rd_start, rd_len;
   logic [2:0]    rd_kind;
   logic [15:0]   rd_ident;
   logic [XW-1:0] amask, pagem1, pmask, size_ext, csr_ext;
   logic [CW-1:0] idx_p1;
   logic          gran_on, pm;

   ffsg_alu #(.W(XW)) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .y      (alu_y),
      .borrow (alu_borrow)
   );

   ffsg_table #(.DEPTH(MAX_SEGMENTS), .IW(IW), .EW(EW)) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (rd_data)
   );

   // entry fields and derived masks
   assign rd_start = rd_data[EW-1 -: AW];
   assign rd_len   = rd_data[EW-AW-1 -: AW];
   assign rd_kind  = rd_data[18:16];
   assign rd_ident = rd_data[15:0];
   assign amask    = (XW'(1) << alog_ff) - XW'(1);
   assign pagem1   = (XW'(1) << gl_ff) - XW'(1);
   assign pmask    = ~pagem1;
   assign size_ext = XW'(size_ff);
   assign csr_ext  = XW'(csr_wdata);
   assign idx_p1   = idx_ff + CW'(1);
   assign gran_on  = (gl_ff != 5'd0);
   assign pm       = (idx_ff != '0) && (prv_kind_ff == ffsg_pkg::KIND_FREE);

   assign req_ready        = (state_ff == ffsg_pkg::S_IDLE) && !init_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_grant_handle = rsp_handle_ff;
   assign rsp_grant_offset = rsp_offset_ff;
   assign rsp_grant_size   = rsp_size_ff;

   // sequencer: next state, adder operands, table accesses
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      prv_start_in  = prv_start_ff;
      prv_len_in    = prv_len_ff;
      prv_kind_in   = prv_kind_ff;
      prv_ident_in  = prv_ident_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      cur_ident_in  = cur_ident_ff;
      nxt_start_in  = nxt_start_ff;
      nxt_len_in    = nxt_len_ff;
      nm_in         = nm_ff;
      mvup_in       = mvup_ff;
      opc_in        = opc_ff;
      init_in       = init_ff;
      rcnt_in       = rcnt_ff;
      offset_in     = offset_ff;
      tmp_in        = tmp_ff;
      padded_in     = padded_ff;
      rem_in        = rem_ff;
      avail_in      = avail_ff;
      size_in       = size_ff;
      alog_in       = alog_ff;
      gl_in         = gl_ff;
      rtype_in      = rtype_ff;
      hnd_in        = hnd_ff;
      nid_in        = nid_ff;
      biu_in        = biu_ff;
      pool_in       = pool_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_offset_in = res_offset_ff;
      res_size_in   = res_size_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      alu_op        = ffsg_pkg::ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;

      unique case (state_ff)
         ffsg_pkg::S_IDLE: begin
            if (init_ff) begin
               // rebuild the single free segment
               mem_we    = 1'b1;
               mem_wdata = {{AW{1'b0}}, pool_ff, ffsg_pkg::KIND_FREE, 16'd0};
               init_in   = 1'b0;
            end else if (req_valid) begin
               opc_in        = req_opcode;
               size_in       = req_request_size;
               alog_in       = req_align_log2;
               rtype_in      = req_resource_type;
               hnd_in        = req_handle;
               res_status_in = ffsg_pkg::RSP_OK;
               res_handle_in = '0;
               res_offset_in = '0;
               res_size_in   = '0;
               idx_in        = '0;
               state_in      = (req_opcode == ffsg_pkg::OP_FREE) ? ffsg_pkg::S_RD
                                                                 : ffsg_pkg::S_AV;
            end
         end
         ffsg_pkg::S_AV: begin
            alu_op = ffsg_pkg::ALU_SUB;
            alu_a  = XW'(pool_ff);
            alu_b  = XW'(biu_ff);
            if (rtype_ff < ffsg_pkg::KIND_BUFFER || rtype_ff > ffsg_pkg::KIND_OPTIMAL) begin
               res_status_in = ffsg_pkg::RSP_NOFIT;
               state_in      = ffsg_pkg::S_DONE;
            end else begin
               avail_in = alu_y;
               state_in = ffsg_pkg::S_AVC;
            end
         end
         ffsg_pkg::S_AVC: begin
            alu_op = ffsg_pkg::ALU_SUB;
            alu_a  = avail_ff;
            alu_b  = size_ext;
            if (alu_borrow) begin
               res_status_in = ffsg_pkg::RSP_NOMEM;
               state_in      = ffsg_pkg::S_DONE;
            end else begin
               state_in = ffsg_pkg::S_RD;
            end
         end
         ffsg_pkg::S_RD: begin
            mem_raddr = idx_ff[IW-1:0];
            if (idx_ff >= count_ff) begin
               res_status_in = (opc_ff == ffsg_pkg::OP_FREE) ? ffsg_pkg::RSP_BADHANDLE
                                                            : ffsg_pkg::RSP_NOFIT;
               state_in      = ffsg_pkg::S_DONE;
            end else begin
               state_in = ffsg_pkg::S_LD;
            end
         end
         ffsg_pkg::S_LD: begin
            alu_op       = ffsg_pkg::ALU_SUB;
            alu_a        = XW'(rd_len);
            alu_b        = size_ext;
            cur_start_in = rd_start;
            cur_len_in   = rd_len;
            cur_ident_in = rd_ident;
            if (opc_ff == ffsg_pkg::OP_FREE) begin
               if (rd_kind != ffsg_pkg::KIND_FREE && rd_ident == hnd_ff) begin
                  nm_in    = 1'b0;
                  state_in = ffsg_pkg::S_F1;
               end else begin
                  prv_start_in = rd_start;
                  prv_len_in   = rd_len;
                  prv_kind_in  = rd_kind;
                  prv_ident_in = rd_ident;
                  idx_in       = idx_p1;
                  state_in     = ffsg_pkg::S_RD;
               end
            end else if (rd_kind != ffsg_pkg::KIND_FREE || alu_borrow) begin
               prv_start_in = rd_start;
               prv_len_in   = rd_len;
               prv_kind_in  = rd_kind;
               prv_ident_in = rd_ident;
               idx_in       = idx_p1;
               state_in     = ffsg_pkg::S_RD;
            end else begin
               state_in = ffsg_pkg::S_A1;
            end
         end
         // align the offset
         ffsg_pkg::S_A1: begin
            alu_a     = XW'(cur_start_ff);
            alu_b     = amask;
            offset_in = alu_y & ~amask;
            if (idx_ff != '0 && gran_on && prv_len_ff != '0 &&
                ffsg_pkg::kinds_clash(prv_kind_ff, rtype_ff)) begin
               state_in = ffsg_pkg::S_A2;
            end else begin
               state_in = ffsg_pkg::S_A5;
            end
         end
         // page conflict with the previous segment
         ffsg_pkg::S_A2: begin
            alu_a    = XW'(prv_start_ff);
            alu_b    = XW'(prv_len_ff);
            tmp_in   = alu_y;
            state_in = ffsg_pkg::S_A3;
         end
         ffsg_pkg::S_A3: begin
            alu_op   = ffsg_pkg::ALU_SUB;
            alu_a    = offset_ff;
            alu_b    = tmp_ff;
            state_in = alu_borrow ? ffsg_pkg::S_A5 : ffsg_pkg::S_A4;
         end
         ffsg_pkg::S_A4: begin
            alu_op   = ffsg_pkg::ALU_SUB;
            alu_a    = tmp_ff;
            alu_b    = XW'(1);
            state_in = ((alu_y & pmask) == (offset_ff & pmask)) ? ffsg_pkg::S_A4B
                                                                : ffsg_pkg::S_A5;
         end
         ffsg_pkg::S_A4B: begin
            alu_a     = offset_ff;
            alu_b     = pagem1;
            offset_in = alu_y & pmask;
            state_in  = ffsg_pkg::S_A5;
         end
         // padded size and fit
         ffsg_pkg::S_A5: begin
            alu_op   = ffsg_pkg::ALU_SUB;
            alu_a    = offset_ff;
            alu_b    = XW'(cur_start_ff);
            tmp_in   = alu_y;
            state_in = ffsg_pkg::S_A6;
         end
         ffsg_pkg::S_A6: begin
            alu_a     = tmp_ff;
            alu_b     = size_ext;
            padded_in = alu_y;
            state_in  = ffsg_pkg::S_A7;
         end
         ffsg_pkg::S_A7: begin
            alu_op = ffsg_pkg::ALU_SUB;
            alu_a  = XW'(cur_len_ff);
            alu_b  = padded_ff;
            rem_in = alu_y;
            if (alu_borrow) begin
               prv_start_in = cur_start_ff;
               prv_len_in   = cur_len_ff;
               prv_kind_in  = ffsg_pkg::KIND_FREE;
               prv_ident_in = cur_ident_ff;
               idx_in       = idx_p1;
               state_in     = ffsg_pkg::S_RD;
            end else begin
               state_in = ffsg_pkg::S_A8;
            end
         end
         ffsg_pkg::S_A8: begin
            alu_op = ffsg_pkg::ALU_SUB;
            alu_a  = avail_ff;
            alu_b  = padded_ff;
            if (alu_borrow) begin
               res_status_in = ffsg_pkg::RSP_NOMEM;
               state_in      = ffsg_pkg::S_DONE;
            end else if (gran_on && idx_p1 < count_ff) begin
               state_in = ffsg_pkg::S_A9;
            end else begin
               state_in = ffsg_pkg::S_C0;
            end
         end
         // page conflict with the next segment
         ffsg_pkg::S_A9: begin
            mem_raddr = idx_p1[IW-1:0];
            state_in  = ffsg_pkg::S_A10;
         end
         ffsg_pkg::S_A10: begin
            nxt_start_in = rd_start;
            state_in     = (size_ff != 32'd0 && ffsg_pkg::kinds_clash(rtype_ff, rd_kind))
                           ? ffsg_pkg::S_A11 : ffsg_pkg::S_C0;
         end
         ffsg_pkg::S_A11: begin
            alu_a    = offset_ff;
            alu_b    = size_ext;
            tmp_in   = alu_y;
            state_in = ffsg_pkg::S_A12;
         end
         ffsg_pkg::S_A12: begin
            alu_op   = ffsg_pkg::ALU_SUB;
            alu_a    = XW'(nxt_start_ff);
            alu_b    = tmp_ff;
            state_in = alu_borrow ? ffsg_pkg::S_C0 : ffsg_pkg::S_A13;
         end
         ffsg_pkg::S_A13: begin
            alu_op = ffsg_pkg::ALU_SUB;
            alu_a  = tmp_ff;
            alu_b  = XW'(1);
            if ((alu_y & pmask) == (XW'(nxt_start_ff) & pmask)) begin
               prv_start_in = cur_start_ff;
               prv_len_in   = cur_len_ff;
               prv_kind_in  = ffsg_pkg::KIND_FREE;
               prv_ident_in = cur_ident_ff;
               idx_in       = idx_p1;
               state_in     = ffsg_pkg::S_RD;
            end else begin
               state_in = ffsg_pkg::S_C0;
            end
         end
         // commit: open a slot for the remainder if needed
         ffsg_pkg::S_C0: begin
            if (rem_ff != '0) begin
               if (count_ff >= CW'(MAX_SEGMENTS)) begin
                  res_status_in = ffsg_pkg::RSP_NOMEM;
                  state_in      = ffsg_pkg::S_DONE;
               end else begin
                  mvup_in  = 1'b1;
                  dst_in   = count_ff;
                  src_in   = count_ff - CW'(1);
                  state_in = ffsg_pkg::S_MV_RD;
               end
            end else begin
               state_in = ffsg_pkg::S_C2;
            end
         end
         ffsg_pkg::S_C1: begin
            alu_a     = offset_ff;
            alu_b     = size_ext;
            mem_we    = 1'b1;
            mem_waddr = idx_p1[IW-1:0];
            mem_wdata = {alu_y[AW-1:0], rem_ff[AW-1:0], ffsg_pkg::KIND_FREE, nid_ff};
            nid_in    = nid_ff + 16'd1;
            count_in  = count_ff + CW'(1);
            state_in  = ffsg_pkg::S_C2;
         end
         ffsg_pkg::S_C2: begin
            alu_a         = XW'(biu_ff);
            alu_b         = padded_ff;
            biu_in        = alu_y[AW-1:0];
            mem_we        = 1'b1;
            mem_waddr     = idx_ff[IW-1:0];
            mem_wdata     = {cur_start_ff, padded_ff[AW-1:0], rtype_ff, cur_ident_ff};
            res_status_in = ffsg_pkg::RSP_OK;
            res_handle_in = cur_ident_ff;
            res_offset_in = offset_ff[31:0];
            res_size_in   = size_ff;
            state_in      = ffsg_pkg::S_DONE;
         end
         // move entries one slot up or down
         ffsg_pkg::S_MV_RD: begin
            mem_raddr = src_ff[IW-1:0];
            if (mvup_ff) begin
               state_in = (dst_ff == idx_p1) ? ffsg_pkg::S_C1 : ffsg_pkg::S_MV_WR;
            end else begin
               state_in = (src_ff >= count_ff) ? ffsg_pkg::S_F_END : ffsg_pkg::S_MV_WR;
            end
         end
         ffsg_pkg::S_MV_WR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff[IW-1:0];
            mem_wdata = rd_data;
            if (mvup_ff) begin
               src_in = src_ff - CW'(1);
               dst_in = dst_ff - CW'(1);
            end else begin
               src_in = src_ff + CW'(1);
               dst_in = dst_ff + CW'(1);
            end
            state_in = ffsg_pkg::S_MV_RD;
         end
         // free: release bytes, look at the next neighbor, merge
         ffsg_pkg::S_F1: begin
            alu_op   = ffsg_pkg::ALU_SUB;
            alu_a    = XW'(biu_ff);
            alu_b    = XW'(cur_len_ff);
            biu_in   = alu_y[AW-1:0];
            state_in = (idx_p1 < count_ff) ? ffsg_pkg::S_F2 : ffsg_pkg::S_F4;
         end
         ffsg_pkg::S_F2: begin
            mem_raddr = idx_p1[IW-1:0];
            state_in  = ffsg_pkg::S_F3;
         end
         ffsg_pkg::S_F3: begin
            nxt_len_in = rd_len;
            nm_in      = (rd_kind == ffsg_pkg::KIND_FREE);
            state_in   = ffsg_pkg::S_F4;
         end
         ffsg_pkg::S_F4: begin
            alu_a    = XW'(cur_len_ff);
            alu_b    = pm ? XW'(prv_len_ff) : '0;
            tmp_in   = alu_y;
            state_in = ffsg_pkg::S_F5;
         end
         ffsg_pkg::S_F5: begin
            alu_a     = tmp_ff;
            alu_b     = nm_ff ? XW'(nxt_len_ff) : '0;
            mem_we    = 1'b1;
            mem_waddr = pm ? (idx_ff[IW-1:0] - IW'(1)) : idx_ff[IW-1:0];
            mem_wdata = {(pm ? prv_start_ff : cur_start_ff), alu_y[AW-1:0],
                         ffsg_pkg::KIND_FREE, (pm ? prv_ident_ff : cur_ident_ff)};
            rcnt_in   = {1'b0, pm} + {1'b0, nm_ff};
            src_in    = idx_p1 + CW'(nm_ff);
            dst_in    = idx_p1 + CW'(nm_ff) - CW'(pm) - CW'(nm_ff);
            mvup_in   = 1'b0;
            state_in  = (pm || nm_ff) ? ffsg_pkg::S_MV_RD : ffsg_pkg::S_F_END;
         end
         ffsg_pkg::S_F_END: begin
            count_in      = count_ff - CW'(rcnt_ff);
            res_status_in = ffsg_pkg::RSP_OK;
            state_in      = ffsg_pkg::S_DONE;
         end
         ffsg_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_offset_in = res_offset_ff;
               rsp_size_in   = res_size_ff;
               state_in      = ffsg_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffsg_pkg::S_IDLE;
         end
      endcase

      // register writes
      if (csr_we) begin
         if (csr_index == ffsg_pkg::CSR_POOL_SIZE) begin
            pool_in  = csr_ext[AW-1:0];
            count_in = CW'(1);
            biu_in   = '0;
            nid_in   = 16'd1;
            init_in  = 1'b1;
         end else begin
            gl_in = csr_wdata[4:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsg_pkg::S_IDLE;
         count_ff     <= CW'(1);
         biu_ff       <= '0;
         nid_ff       <= 16'd1;
         pool_ff      <= '0;
         gl_ff        <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         biu_ff       <= biu_in;
         nid_ff       <= nid_in;
         pool_ff      <= pool_in;
         gl_ff        <= gl_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      prv_start_ff  <= prv_start_in;
      prv_len_ff    <= prv_len_in;
      prv_kind_ff   <= prv_kind_in;
      prv_ident_ff  <= prv_ident_in;
      cur_start_ff  <= cur_start_in;
      cur_len_ff    <= cur_len_in;
      cur_ident_ff  <= cur_ident_in;
      nxt_start_ff  <= nxt_start_in;
      nxt_len_ff    <= nxt_len_in;
      nm_ff         <= nm_in;
      mvup_ff       <= mvup_in;
      opc_ff        <= opc_in;
      rcnt_ff       <= rcnt_in;
      offset_ff     <= offset_in;
      tmp_ff        <= tmp_in;
      padded_ff     <= padded_in;
      rem_ff        <= rem_in;
      avail_ff      <= avail_in;
      size_ff       <= size_in;
      alog_ff       <= alog_in;
      rtype_ff      <= rtype_in;
      hnd_ff        <= hnd_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_offset_ff <= res_offset_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff   <= rsp_size_in;
   end

   // table never empty and never past capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");

   // allocated bytes stay inside the pool
   a_biu_bound: assert property (@(posedge clock) disable iff (reset)
      biu_ff <= pool_ff)
      else $error("bytes in use exceed pool size");

   // entry moves stay inside the live table
   a_move_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffsg_pkg::S_MV_WR |-> dst_ff <= count_ff)
      else $error("entry move past table end");

endmodule

FILE: rtl/core/ffsg_alu.sv
module ffsg_alu #(
   parameter int W = 34
) (
   input  ffsg_pkg::aluop_type op,
   input  logic [W-1:0]        a,
   input  logic [W-1:0]        b,
   output logic [W-1:0]        y,
   output logic                borrow
);

   logic [W:0] diff;

   // shared add / subtract, borrow flags a < b
   assign diff   = {1'b0, a} - {1'b0, b};
   assign borrow = diff[W];
   assign y      = (op == ffsg_pkg::ALU_ADD) ? (a + b) : diff[W-1:0];

endmodule

FILE: rtl/core/ffsg_table.sv
module ffsg_table #(
   parameter int DEPTH = 64,
   parameter int IW    = 6,
   parameter int EW    = 83
) (
   input  logic          clock,
   input  logic          we,
   input  logic [IW-1:0] waddr,
   input  logic [EW-1:0] wdata,
   input  logic [IW-1:0] raddr,
   output logic [EW-1:0] rdata
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
